// File: sv/lmt_pkg.sv
package lmt_pkg;

   localparam int DOTS_PER_LINE     = 456;
   localparam int VBLANK_FIRST_LINE = 144;
   localparam int LINES_PER_FRAME   = 154;
   localparam int SCAN_END_DOT      = 80;
   localparam int DRAW_END_DOT      = 256;

   localparam int DOT_W  = 10;
   localparam int LINE_W = 8;
   localparam int DATA_W = 8;
   localparam int TICK_W = 8;
   localparam int SUM_W  = DOT_W + 1;

   localparam int SUM_MAX    = (1 << DOT_W) - 1 + (1 << TICK_W) - 1;
   localparam int WRAP_STEPS = SUM_MAX / DOTS_PER_LINE;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   localparam logic [3:0] OFS_CONTROL = 4'd0;
   localparam logic [3:0] OFS_STATUS  = 4'd1;
   localparam logic [3:0] OFS_SCY     = 4'd2;
   localparam logic [3:0] OFS_SCX     = 4'd3;
   localparam logic [3:0] OFS_LINE    = 4'd4;
   localparam logic [3:0] OFS_COMPARE = 4'd5;
   localparam logic [3:0] OFS_BGP     = 4'd7;
   localparam logic [3:0] OFS_OBP0    = 4'd8;
   localparam logic [3:0] OFS_OBP1    = 4'd9;
   localparam logic [3:0] OFS_WY      = 4'd10;
   localparam logic [3:0] OFS_WX      = 4'd11;

   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_SCAN   = 2'd2;
   localparam logic [1:0] MODE_DRAW   = 2'd3;

   localparam logic [DATA_W-1:0] OBJ_PAL_MASK = 8'hFC;

   // Interrupt enable positions within the status bits 6 down to 3.
   localparam int EN_HBLANK  = 0;
   localparam int EN_VBLANK  = 1;
   localparam int EN_SCAN    = 2;
   localparam int EN_COMPARE = 3;

   typedef enum logic [3:0] {
      ST_HBLANK = 4'b0001,
      ST_VBLANK = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DRAW   = 4'b1000
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [3:0]        reg_offset;
      logic [DATA_W-1:0] write_data;
      logic [TICK_W-1:0] dots;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
      logic              vblank_irq;
      logic              stat_irq;
      logic              scan_done;
      logic              line_done;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        irq_en;
      logic [LINE_W-1:0] compare;
   } ctl_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
      logic              coinc;
   } sts_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [LINE_W-1:0] line;
      logic              vblank_irq;
      logic              stat_irq;
      logic              scan_done;
      logic              line_done;
   } evt_type;

   function automatic logic [1:0] mode_code(input state_type st);
      logic [1:0] code;
      case (st)
         ST_HBLANK: code = MODE_HBLANK;
         ST_VBLANK: code = MODE_VBLANK;
         ST_SCAN:   code = MODE_SCAN;
         default:   code = MODE_DRAW;
      endcase
      return code;
   endfunction

   function automatic logic [DOT_W-1:0] wrap_dots(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] r;
      r = sum;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (r >= SUM_W'(DOTS_PER_LINE)) begin
            r = r - SUM_W'(DOTS_PER_LINE);
         end
      end
      return r[DOT_W-1:0];
   endfunction

endpackage

// File: sv/lmt_if.sv
interface lmt_req_if;
   import lmt_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [3:0]        reg_offset;
   logic [DATA_W-1:0] write_data;
   logic [TICK_W-1:0] dots;

   modport source (output valid, kind, reg_offset, write_data, dots, input ready);
   modport sink (input valid, kind, reg_offset, write_data, dots, output ready);
endinterface

interface lmt_rsp_if;
   import lmt_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [1:0]        mode;
   logic [LINE_W-1:0] line;
   logic              vblank_irq;
   logic              stat_irq;
   logic              scan_done;
   logic              line_done;

   modport source (output valid, read_data, mode, line, vblank_irq, stat_irq,
                   scan_done, line_done, input ready);
   modport sink (input valid, read_data, mode, line, vblank_irq, stat_irq,
                 scan_done, line_done, output ready);
endinterface

// File: sv/lmt_regs.sv
module lmt_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [3:0]                reg_offset,
   input  logic [lmt_pkg::DATA_W-1:0] write_data,
   input  lmt_pkg::sts_type          sts,
   output logic [lmt_pkg::DATA_W-1:0] read_data,
   output lmt_pkg::ctl_type          ctl
);
   import lmt_pkg::*;

   logic [DATA_W-1:0] control_ff;
   logic [4:0]        stat_hi_ff;
   logic [LINE_W-1:0] compare_ff;
   logic [DATA_W-1:0] plain_ff [7];

   logic              slot_vld;
   logic [2:0]        slot;
   logic [DATA_W-1:0] plain_in;

   always_comb begin
      slot_vld = 1'b1;
      slot     = 3'd0;
      case (reg_offset)
         OFS_SCY:  slot = 3'd0;
         OFS_SCX:  slot = 3'd1;
         OFS_BGP:  slot = 3'd2;
         OFS_OBP0: slot = 3'd3;
         OFS_OBP1: slot = 3'd4;
         OFS_WY:   slot = 3'd5;
         OFS_WX:   slot = 3'd6;
         default:  slot_vld = 1'b0;
      endcase
   end

   always_comb begin
      plain_in = write_data;
      if (reg_offset inside {OFS_OBP0, OFS_OBP1}) begin
         plain_in = write_data & OBJ_PAL_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         stat_hi_ff <= 5'b10000;
         compare_ff <= '0;
         for (int i = 0; i < 7; i++) begin
            plain_ff[i] <= '0;
         end
      end else if (wr_en) begin
         case (reg_offset)
            OFS_CONTROL: control_ff <= write_data;
            OFS_STATUS:  stat_hi_ff <= write_data[7:3];
            OFS_COMPARE: compare_ff <= write_data;
            default: begin
               if (slot_vld) begin
                  plain_ff[slot] <= plain_in;
               end
            end
         endcase
      end
   end

   always_comb begin
      case (reg_offset)
         OFS_CONTROL: read_data = control_ff;
         OFS_STATUS:  read_data = {stat_hi_ff, sts.coinc, sts.mode};
         OFS_LINE:    read_data = sts.line;
         OFS_COMPARE: read_data = compare_ff;
         default:     read_data = slot_vld ? plain_ff[slot] : '0;
      endcase
   end

   assign ctl.irq_en  = stat_hi_ff[3:0];
   assign ctl.compare = compare_ff;

endmodule

// File: sv/lmt_timing.sv
module lmt_timing (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [lmt_pkg::TICK_W-1:0] dots,
   input  lmt_pkg::ctl_type          ctl,
   output lmt_pkg::sts_type          sts,
   output lmt_pkg::evt_type          evt
);
   import lmt_pkg::*;

   logic [DOT_W-1:0]  dot_ff,   dot_in;
   logic [LINE_W-1:0] line_ff,  line_in;
   state_type         state_ff, state_in;
   logic              coinc_ff, coinc_in;

   logic [SUM_W-1:0]  sum;
   logic [LINE_W-1:0] line_inc;
   logic              wrapped;
   logic              vb, st, sd, ld;

   assign sum      = SUM_W'(dot_ff) + SUM_W'(dots);
   assign line_inc = line_ff + LINE_W'(1);

   always_comb begin
      wrapped  = 1'b0;
      dot_in   = sum[DOT_W-1:0];
      line_in  = line_ff;
      state_in = state_ff;
      vb = 1'b0;
      st = 1'b0;
      sd = 1'b0;
      ld = 1'b0;
      case (state_ff)
         ST_HBLANK: begin
            if (sum >= SUM_W'(DOTS_PER_LINE)) begin
               wrapped = 1'b1;
               line_in = line_inc;
               if (line_inc == LINE_W'(VBLANK_FIRST_LINE)) begin
                  state_in = ST_VBLANK;
                  vb = 1'b1;
                  st = ctl.irq_en[EN_VBLANK];
               end else begin
                  state_in = ST_SCAN;
                  st = ctl.irq_en[EN_SCAN];
               end
            end
         end
         ST_VBLANK: begin
            if (sum >= SUM_W'(DOTS_PER_LINE)) begin
               wrapped = 1'b1;
               line_in = line_inc;
               if (line_inc == LINE_W'(LINES_PER_FRAME)) begin
                  line_in  = '0;
                  state_in = ST_SCAN;
                  st = ctl.irq_en[EN_SCAN];
               end
            end
         end
         ST_SCAN: begin
            if (sum >= SUM_W'(SCAN_END_DOT)) begin
               state_in = ST_DRAW;
               sd = 1'b1;
            end
         end
         default: begin
            if (sum >= SUM_W'(DRAW_END_DOT)) begin
               state_in = ST_HBLANK;
               ld = 1'b1;
               st = ctl.irq_en[EN_HBLANK];
            end
         end
      endcase
      if (wrapped) begin
         dot_in = wrap_dots(sum);
      end
      coinc_in = (line_in == ctl.compare);
      if (coinc_in && ctl.irq_en[EN_COMPARE]) begin
         st = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= '0;
         line_ff  <= LINE_W'(VBLANK_FIRST_LINE);
         state_ff <= ST_VBLANK;
         coinc_ff <= 1'b0;
      end else if (step) begin
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         state_ff <= state_in;
         coinc_ff <= coinc_in;
      end
   end

   assign sts.mode  = mode_code(state_ff);
   assign sts.line  = line_ff;
   assign sts.coinc = coinc_ff;

   assign evt.mode       = step ? mode_code(state_in) : mode_code(state_ff);
   assign evt.line       = step ? line_in : line_ff;
   assign evt.vblank_irq = step & vb;
   assign evt.stat_irq   = step & st;
   assign evt.scan_done  = step & sd;
   assign evt.line_done  = step & ld;

endmodule

// File: sv/lcd_mode_timing_registers_unit.sv
// Channel  Dir  Beat contents
// req      in   kind, reg_offset, write_data, dots
// rsp      out  read_data, mode, line, vblank_irq, stat_irq, scan_done, line_done
//
// Every request beat gives exactly one response beat, via the input register and
// then the result register. One beat is accepted per cycle while the response
// is not stalled; each register holds one beat; the state steps once per tick beat.
// Reset is synchronous and active high; it puts the sequencer in vblank on line 144.
// A stalled response holds the result register, and the input register fills
// behind it before req.ready drops.
module lcd_mode_timing_registers_unit (
   input logic   clock,
   input logic   reset,
   lmt_req_if.sink   req,
   lmt_rsp_if.source rsp
);
   import lmt_pkg::*;

   req_type item_ff, item_in;
   logic    item_vld_ff;
   rsp_type res_ff, res_in;
   logic    res_vld_ff;

   logic              advance;
   logic              take;
   logic              fire;
   logic              step;
   logic              wr_en;
   logic [DATA_W-1:0] rd_data;
   ctl_type           ctl;
   sts_type           sts;
   evt_type           evt;

   assign advance   = !res_vld_ff || rsp.ready;
   assign req.ready = !item_vld_ff || advance;
   assign take      = req.valid && req.ready;
   assign fire      = item_vld_ff && advance;
   assign step      = fire && (item_ff.kind == KIND_TICK);
   assign wr_en     = fire && (item_ff.kind == KIND_WRITE);

   assign item_in.kind       = req.kind;
   assign item_in.reg_offset = req.reg_offset;
   assign item_in.write_data = req.write_data;
   assign item_in.dots       = req.dots;

   lmt_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .reg_offset (item_ff.reg_offset),
      .write_data (item_ff.write_data),
      .sts        (sts),
      .read_data  (rd_data),
      .ctl        (ctl)
   );

   lmt_timing u_timing (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .dots  (item_ff.dots),
      .ctl   (ctl),
      .sts   (sts),
      .evt   (evt)
   );

   always_comb begin
      res_in.read_data  = (item_ff.kind == KIND_READ) ? rd_data : '0;
      res_in.mode       = evt.mode;
      res_in.line       = evt.line;
      res_in.vblank_irq = evt.vblank_irq;
      res_in.stat_irq   = evt.stat_irq;
      res_in.scan_done  = evt.scan_done;
      res_in.line_done  = evt.line_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         if (req.ready) begin
            item_vld_ff <= req.valid;
         end
         if (advance) begin
            res_vld_ff <= item_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid      = res_vld_ff;
   assign rsp.read_data  = res_ff.read_data;
   assign rsp.mode       = res_ff.mode;
   assign rsp.line       = res_ff.line;
   assign rsp.vblank_irq = res_ff.vblank_irq;
   assign rsp.stat_irq   = res_ff.stat_irq;
   assign rsp.scan_done  = res_ff.scan_done;
   assign rsp.line_done  = res_ff.line_done;

   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.vblank_irq |-> rsp.mode == MODE_VBLANK)
      else $error("vblank pulse outside vblank");

   a_scan_mode: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.scan_done |-> rsp.mode == MODE_DRAW)
      else $error("scan done without entering draw");

   a_draw_mode: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.line_done |-> rsp.mode == MODE_HBLANK)
      else $error("line done without entering hblank");

   a_item_hold: assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && !advance |=> item_vld_ff && $stable(item_ff))
      else $error("input register lost a pending beat");

endmodule
